@@ hdl/rgb2hsv_pkg.sv @@
// Shared types and constants for the RGBA to HSV pixel converter.
// No dependencies; every module of the converter imports this package.
package rgb2hsv_pkg;

  localparam int CH_W        = 8;
  localparam int NUM_W       = 16;
  localparam int TDATA_W     = 32;
  localparam int DIV_STAGES  = 8;
  localparam int PIPE_STAGES = DIV_STAGES + 2;

  localparam logic [CH_W-1:0] HUE_STEP     = CH_W'(255 / 6);
  localparam logic [CH_W-1:0] OFFSET_GREEN = CH_W'(255 / 3);
  localparam logic [CH_W-1:0] OFFSET_BLUE  = CH_W'((255 * 2) / 3);
  localparam logic [CH_W-1:0] HUE_MODULUS  = CH_W'(255);
  localparam logic [CH_W-1:0] SAT_FULL     = CH_W'(255);

  // Hue sector, chosen with grey (max equal to min) tested first, then red, then green, then blue
  typedef enum logic [1:0] {
    SEC_GREY,
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // Input pixel, first field in the highest bits
  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pix_in_t;

  // Result pixel, first field in the highest bits
  typedef struct packed {
    logic [CH_W-1:0] alpha_out;
    logic [CH_W-1:0] brightness;
    logic [CH_W-1:0] saturation;
    logic [CH_W-1:0] hue;
  } pix_out_t;

  // Payload carried through the divider stages
  typedef struct packed {
    logic [NUM_W-1:0] hrem;    // hue remainder
    logic [CH_W-1:0]  hden;    // max - min
    logic [NUM_W-1:0] srem;    // saturation remainder
    logic [CH_W-1:0]  sden;    // max, also the brightness
    logic [CH_W-1:0]  hq;      // hue quotient magnitude
    logic [CH_W-1:0]  sq;      // min*255/max quotient
    logic             neg;     // hue difference is negative
    sector_t          sector;
    logic [CH_W-1:0]  alpha;
  } div_t;

endpackage

@@ hdl/rgb2hsv_front.sv @@
// First stage: max, min, sector and the two dividends of the converter.
// Depends on rgb2hsv_pkg.
module rgb2hsv_front (
  input  logic                 clk,
  input  logic                 en,
  input  rgb2hsv_pkg::pix_in_t pix,
  output rgb2hsv_pkg::div_t    dat_r
);
  import rgb2hsv_pkg::*;

  logic            red_max;
  logic            grn_max;
  logic [CH_W-1:0] mx;
  logic [CH_W-1:0] mn;
  logic [CH_W-1:0] da;
  logic [CH_W-1:0] db;
  logic [CH_W-1:0] mag;
  sector_t         sector;
  div_t            dat_nxt;

  // Find max and min, pick the sector
  always_comb begin
    red_max = (pix.red >= pix.green) && (pix.red >= pix.blue);
    grn_max = (pix.green >= pix.blue);
    if (red_max) begin
      mx = pix.red;
    end else if (grn_max) begin
      mx = pix.green;
    end else begin
      mx = pix.blue;
    end
    mn = pix.red;
    if (pix.green < mn) mn = pix.green;
    if (pix.blue < mn) mn = pix.blue;

    if (mx == mn) begin
      sector = SEC_GREY;
    end else if (red_max) begin
      sector = SEC_RED;
    end else if (grn_max) begin
      sector = SEC_GREEN;
    end else begin
      sector = SEC_BLUE;
    end
  end

  // Select the signed channel difference and build the dividends
  always_comb begin
    case (sector)
      SEC_GREEN: begin
        da = pix.blue;
        db = pix.red;
      end
      SEC_BLUE: begin
        da = pix.red;
        db = pix.green;
      end
      default: begin
        da = pix.green;
        db = pix.blue;
      end
    endcase
    dat_nxt.neg = (da < db);
    mag = dat_nxt.neg ? (db - da) : (da - db);

    dat_nxt.hrem   = NUM_W'(mag) * NUM_W'(HUE_STEP);
    dat_nxt.hden   = mx - mn;
    dat_nxt.srem   = NUM_W'(mn) * NUM_W'(SAT_FULL);
    dat_nxt.sden   = mx;
    dat_nxt.hq     = '0;
    dat_nxt.sq     = '0;
    dat_nxt.sector = sector;
    dat_nxt.alpha  = pix.alpha;
  end

  // Advance on the stage enable
  always_ff @(posedge clk) begin
    if (en) begin
      dat_r <= dat_nxt;
    end
  end

endmodule

@@ hdl/rgb2hsv_div.sv @@
// Pipelined restoring divider: one quotient bit per stage for hue and saturation.
// Depends on rgb2hsv_pkg.
module rgb2hsv_div (
  input  logic                                clk,
  input  logic [rgb2hsv_pkg::DIV_STAGES-1:0]  en,
  input  rgb2hsv_pkg::div_t                   dat_in,
  output rgb2hsv_pkg::div_t                   dat_out
);
  import rgb2hsv_pkg::*;

  div_t src     [DIV_STAGES];
  div_t stg_nxt [DIV_STAGES];
  div_t stg_r   [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stg
    localparam int SH = DIV_STAGES - 1 - i;

    logic [NUM_W-1:0] hsub;
    logic [NUM_W-1:0] ssub;

    // Chain each stage to the one before it
    if (i == 0) begin : g_first
      assign src[i] = dat_in;
    end else begin : g_next
      assign src[i] = stg_r[i-1];
    end

    // Trial subtract of the shifted divisors
    always_comb begin
      stg_nxt[i] = src[i];
      hsub = NUM_W'(src[i].hden) << SH;
      ssub = NUM_W'(src[i].sden) << SH;
      if (src[i].hrem >= hsub) begin
        stg_nxt[i].hrem   = src[i].hrem - hsub;
        stg_nxt[i].hq[SH] = 1'b1;
      end
      if (src[i].srem >= ssub) begin
        stg_nxt[i].srem   = src[i].srem - ssub;
        stg_nxt[i].sq[SH] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        stg_r[i] <= stg_nxt[i];
      end
    end
  end

  assign dat_out = stg_r[DIV_STAGES-1];

endmodule

@@ hdl/rgb2hsv_back.sv @@
// Last stage: sector offset and wrap for hue, saturation, output register.
// Depends on rgb2hsv_pkg.
module rgb2hsv_back (
  input  logic                  clk,
  input  logic                  en,
  input  rgb2hsv_pkg::div_t     dat,
  output rgb2hsv_pkg::pix_out_t pix_r
);
  import rgb2hsv_pkg::*;

  pix_out_t pix_nxt;

  // Apply the sector offset to the signed quotient
  always_comb begin
    case (dat.sector)
      SEC_RED: begin
        if (dat.neg && (dat.hq != '0)) begin
          pix_nxt.hue = HUE_MODULUS - dat.hq;
        end else begin
          pix_nxt.hue = dat.hq;
        end
      end
      SEC_GREEN: begin
        pix_nxt.hue = dat.neg ? (OFFSET_GREEN - dat.hq) : (OFFSET_GREEN + dat.hq);
      end
      SEC_BLUE: begin
        pix_nxt.hue = dat.neg ? (OFFSET_BLUE - dat.hq) : (OFFSET_BLUE + dat.hq);
      end
      default: begin
        pix_nxt.hue = '0;
      end
    endcase
    pix_nxt.saturation = (dat.sden == '0) ? '0 : (SAT_FULL - dat.sq);
    pix_nxt.brightness = dat.sden;
    pix_nxt.alpha_out  = dat.alpha;
  end

  // Hold the result until the stage enable
  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

@@ hdl/rgb_to_hsv_8bit.sv @@
// RGBA to HSV converter, top level; depends on rgb2hsv_pkg and its stage modules.
// Pipeline: 10 register stages, the front stage, the divider stages and the back stage.
// Throughput: one pixel per clock while the output is not stalled, with the one-bit-per-stage divider pipelined.
// Each stage moves on when the stage after it is empty or moving, so bubbles close up.
// Reset: synchronous, active low; clears all stage valid bits, data is not reset.
module rgb_to_hsv_8bit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rgb2hsv_pkg::TDATA_W-1:0] in_tdata,   // red, green, blue, alpha
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rgb2hsv_pkg::TDATA_W-1:0] out_tdata   // hue, saturation, brightness, alpha_out
);
  import rgb2hsv_pkg::*;

  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES-1:0] vld_nxt;
  logic [PIPE_STAGES-1:0] adv;
  div_t                   front_dat;
  div_t                   div_dat;
  pix_out_t               pix;

  // Stage advance: a stage moves when it is empty or the next one moves
  always_comb begin
    adv[PIPE_STAGES-1] = out_tready | ~vld_r[PIPE_STAGES-1];
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      adv[i] = adv[i+1] | ~vld_r[i];
    end
  end

  // Shift valid bits along with the data
  always_comb begin
    vld_nxt[0] = adv[0] ? in_tvalid : vld_r[0];
    for (int i = 1; i < PIPE_STAGES; i++) begin
      vld_nxt[i] = adv[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  rgb2hsv_front u_front (
    .clk   (clk),
    .en    (adv[0]),
    .pix   (pix_in_t'(in_tdata)),
    .dat_r (front_dat)
  );

  rgb2hsv_div u_div (
    .clk     (clk),
    .en      (adv[DIV_STAGES:1]),
    .dat_in  (front_dat),
    .dat_out (div_dat)
  );

  rgb2hsv_back u_back (
    .clk   (clk),
    .en    (adv[PIPE_STAGES-1]),
    .dat   (div_dat),
    .pix_r (pix)
  );

  assign in_tready  = adv[0];
  assign out_tvalid = vld_r[PIPE_STAGES-1];
  assign out_tdata  = TDATA_W'(pix);

  // Hue never reaches the full-circle code
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (pix.hue != HUE_MODULUS))
    else $error("hue out of range");

  // Zero saturation only for grey, which has zero hue
  a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (pix.saturation == '0)) |-> (pix.hue == '0))
    else $error("grey pixel with nonzero hue");

  // Black gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (pix.brightness == '0)) |-> ((pix.hue == '0) && (pix.saturation == '0)))
    else $error("black pixel with nonzero hue or saturation");

  // A taken result frees the whole pipeline for a new request
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is taken");

endmodule
